// ----- hdl/can_se_pkg.sv -----
// Shared types and constants for the CAN signal extractor.
// Holds the result status codes and the job record passed from the front part to the back part.
// No dependencies.
package can_se_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SKIP  = 2'd2
    } status_t;

    // A stored selector of this value disables the multiplexor filter.
    localparam logic [7:0] NO_FILTER = 8'hFF;

    // Job queue depth between the front and back parts (power of two).
    localparam int JOB_DEPTH = 2;

    // One classified signal, waiting to be scaled.
    typedef struct packed {
        logic [63:0]        raw;
        logic signed [31:0] factor;
        logic [63:0]        offset;
        status_t            status;
        logic               is_mux;
    } job_t;

endpackage

// ----- hdl/can_signal_extractor.sv -----
// Top level of the CAN signal extractor: decodes one CAN signal per request.
// Instantiates can_se_front, can_se_queue and can_se_back; depends on can_se_pkg.
//
// Usage:
//   Input stream s_axis carries one CAN frame plus one signal description per request.
//   The request is taken at a clock edge where s_axis_tvalid and s_axis_tready are high.
//   Output stream m_axis returns exactly one result per request, in order: the scaled
//   value in m_axis_tdata and the status (decoded, out of range, skipped) in m_axis_tuser.
// Timing:
//   The front part checks, extracts and filters in the accept cycle and writes a job to a
//   two-entry queue. The back part registers two partial products of the 32-bit raw halves
//   in its product stage, then the 64-bit sum in its sum stage, which holds the result.
//   Throughput, set by the multiplier stage, is one request per cycle without output stalls.
// Reset:
//   rst_n clears the queue and pipeline and sets the stored selector to no filter.
// Stalls:
//   When m_axis_tready is low the result holds; the pipeline and then the queue fill, and
//   s_axis_tready drops only once the queue is full.
module can_signal_extractor
    import can_se_pkg::*;
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] frame_data, [67:64] frame_bytes, [73:68] start_bit, [80:74] size_bits,
    // [112:81] factor, [176:113] offset, [183:177] zero
    input  logic [183:0] s_axis_tdata,
    // [0] big_endian, [1] is_signed, [2] is_multiplexor, [10:3] mux_select,
    // [11] new_message, [15:12] zero
    input  logic [15:0]  s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] value
    output logic [63:0]  m_axis_tdata,
    // [1:0] status, [7:2] zero
    output logic [7:0]   m_axis_tuser
);

    logic    accept;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    job_t    front_job;
    job_t    back_job;
    status_t out_status;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    can_se_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .frame_data    (s_axis_tdata[63:0]),
        .frame_bytes   (s_axis_tdata[67:64]),
        .start_bit     (s_axis_tdata[73:68]),
        .size_bits     (s_axis_tdata[80:74]),
        .big_endian    (s_axis_tuser[0]),
        .is_signed     (s_axis_tuser[1]),
        .factor        (s_axis_tdata[112:81]),
        .offset        (s_axis_tdata[176:113]),
        .is_multiplexor(s_axis_tuser[2]),
        .mux_select    (s_axis_tuser[10:3]),
        .new_message   (s_axis_tuser[11]),
        .job           (front_job)
    );

    can_se_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .push_job(front_job),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .pop_job (back_job)
    );

    can_se_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (back_job),
        .job_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_status(out_status)
    );

    assign m_axis_tuser = {6'b000000, out_status};

endmodule

// ----- hdl/can_se_front.sv -----
// Front part of the CAN signal extractor: range check, bit extraction and multiplexor filter.
// Produces one job per accepted request and owns the stored multiplexor selector.
// Depends on can_se_pkg.
module can_se_front
    import can_se_pkg::*;
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [63:0]        frame_data,
    input  logic [3:0]         frame_bytes,
    input  logic [5:0]         start_bit,
    input  logic [6:0]         size_bits,
    input  logic               big_endian,
    input  logic               is_signed,
    input  logic signed [31:0] factor,
    input  logic [63:0]        offset,
    input  logic               is_multiplexor,
    input  logic [7:0]         mux_select,
    input  logic               new_message,
    output job_t               job
);

    logic [7:0]  cur_mux_reg;
    logic [7:0]  cur_mux_next;
    logic [7:0]  cur_mux_eff;
    logic [3:0]  nbytes;
    logic [6:0]  nbits;
    logic [6:0]  start_ext;
    logic [3:0]  sb_p1;
    logic [6:0]  moto_room;
    logic [6:0]  intel_end;
    logic        in_range;
    logic        skip;
    logic [63:0] rev_data;
    logic [63:0] src;
    logic [5:0]  amt;
    logic [63:0] shifted;
    logic [63:0] mask;
    logic [63:0] raw_m;
    logic [5:0]  top_idx;
    logic [63:0] raw;
    logic [7:0]  mux_byte;
    status_t     status;

    // Clamp the frame length and check that the signal lies in the payload.
    always_comb
    begin
        nbytes    = (frame_bytes > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : frame_bytes;
        nbits     = {nbytes, 3'b000};
        start_ext = {1'b0, start_bit};
        sb_p1     = {1'b0, start_bit[5:3]} + 4'd1;
        moto_room = {sb_p1, 3'b000} - {4'b0000, start_bit[2:0]};
        intel_end = start_ext + size_bits;
        in_range  = (start_ext < nbits) && (size_bits != 7'd0) && (size_bits <= nbits) &&
                    (big_endian ? (size_bits <= moto_room) : (intel_end <= nbits));
    end

    // Extract the raw bits; Motorola order reads the byte-reversed frame.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            rev_data[8*k +: 8] = frame_data[8*(7-k) +: 8];
        end
        src     = big_endian ? rev_data : frame_data;
        amt     = big_endian ? {~start_bit[5:3], start_bit[2:0]} : start_bit;
        shifted = src >> amt;
        mask    = size_bits[6] ? '1 : ((64'd1 << size_bits[5:0]) - 64'd1);
        raw_m   = shifted & mask;
        top_idx = 6'(size_bits - 7'd1);
        raw     = (is_signed && raw_m[top_idx]) ? (raw_m | ~mask) : raw_m;
        // The low byte of the scaled value needs only the low bytes of each operand.
        mux_byte = 8'(raw[7:0] * factor[7:0]) + offset[7:0];
    end

    // Multiplexor filter and status.
    always_comb
    begin
        cur_mux_eff = new_message ? NO_FILTER : cur_mux_reg;
        skip        = !is_multiplexor && (cur_mux_eff != NO_FILTER) &&
                      (mux_select != cur_mux_eff);
        if (skip)
        begin
            status = ST_SKIP;
        end
        else if (!in_range)
        begin
            status = ST_RANGE;
        end
        else
        begin
            status = ST_OK;
        end
        cur_mux_next = cur_mux_reg;
        if (accept)
        begin
            if (is_multiplexor && (status == ST_OK))
            begin
                cur_mux_next = mux_byte;
            end
            else
            begin
                cur_mux_next = cur_mux_eff;
            end
        end
    end

    assign job.raw    = raw;
    assign job.factor = factor;
    assign job.offset = offset;
    assign job.status = status;
    assign job.is_mux = is_multiplexor;

    // Stored selector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mux_reg <= NO_FILTER;
        end
        else
        begin
            cur_mux_reg <= cur_mux_next;
        end
    end

`ifndef ASSERT_OFF
    // The selector only changes when a request is taken.
    a_mux_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cur_mux_reg))
        else $error("selector changed without a request");

    // A new message that is not a multiplexor leaves the filter open.
    a_new_msg: assert property (@(posedge clk) disable iff (!rst_n)
        accept && new_message && !is_multiplexor |=> cur_mux_reg == NO_FILTER)
        else $error("new message did not clear the selector");

    // A multiplexor item is never skipped.
    a_mux_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_multiplexor |-> status != ST_SKIP)
        else $error("multiplexor item was skipped");
`endif

endmodule

// ----- hdl/can_se_queue.sv -----
// Short job queue between the front and back parts of the CAN signal extractor.
// Register storage, one push and one pop per cycle.
// Depends on can_se_pkg.
module can_se_queue
    import can_se_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t pop_job
);

    localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CW = $clog2(JOB_DEPTH + 1);

    job_t            store_reg [JOB_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full    = (count_reg == CW'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = store_reg[rd_ptr_reg];

    // Pointer and fill-count update; the depth is a power of two so pointers wrap naturally.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef ASSERT_OFF
    // No push into a full queue, no pop from an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("job queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(JOB_DEPTH))
        else $error("job queue count out of bounds");
`endif

endmodule

// ----- hdl/can_se_back.sv -----
// Back part of the CAN signal extractor: scales the raw value by factor and adds offset.
// Two register stages: partial products, then the sum, held in the result register.
// Depends on can_se_pkg.
module can_se_back
    import can_se_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_value,
    output status_t     out_status
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [63:0]        s1_plo_reg;
    logic [31:0]        s1_phi_reg;
    logic [63:0]        s1_offset_reg;
    status_t            s1_status_reg;
    logic               s1_mux_reg;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [63:0]        s2_value_reg;
    status_t            s2_status_reg;
    logic               s2_load;
    logic               s1_load;
    logic signed [63:0] prod_lo;
    logic [31:0]        prod_hi;
    logic [63:0]        sum;

    // Stall control: the result register frees when empty or taken.
    assign s2_load = !s2_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || s2_load;
    assign job_pop = s1_load && job_valid;

    // Partial products: low raw half times signed factor, high half times factor, low 32 bits.
    always_comb
    begin
        prod_lo = $signed({1'b0, job.raw[31:0]}) * job.factor;
        prod_hi = job.raw[63:32] * job.factor;
        sum     = s1_plo_reg + {s1_phi_reg, 32'h0} + s1_offset_reg;
        s1_valid_next = s1_load ? job_valid : s1_valid_reg;
        s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_plo_reg    <= prod_lo;
            s1_phi_reg    <= prod_hi;
            s1_offset_reg <= job.offset;
            s1_status_reg <= job.status;
            s1_mux_reg    <= job.is_mux;
        end
    end

    // Sum stage; failed signals report zero, multiplexor items keep the low byte.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_status_reg <= s1_status_reg;
            if (s1_status_reg != ST_OK)
            begin
                s2_value_reg <= '0;
            end
            else if (s1_mux_reg)
            begin
                s2_value_reg <= {56'h0, sum[7:0]};
            end
            else
            begin
                s2_value_reg <= sum;
            end
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_value  = s2_value_reg;
    assign out_status = s2_status_reg;

`ifndef ASSERT_OFF
    // A stalled result holds until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result changed while stalled");

    // A result that was not decoded carries zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_OK |-> out_value == 64'h0)
        else $error("nonzero value on failed signal");

    // Popping a job always lands in the product stage next cycle.
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> s1_valid_reg)
        else $error("popped job lost");
`endif

endmodule

// ----- verif/can_signal_extractor_tb.sv -----
// Self-checking testbench for can_signal_extractor: a directed table, then random requests.
// Each accepted request is decoded by a local signal decoder and compared with the output stream.
// Depends on can_se_pkg and can_signal_extractor.
module can_signal_extractor_tb;
    import can_se_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 3;
    localparam int PHASE_ITEMS   = 400;
    localparam int DRAIN_CYCLES  = 20;

    // One signal decode request, field by field.
    typedef struct {
        logic [63:0] frame_data;
        logic [3:0]  frame_bytes;
        logic [5:0]  start_bit;
        logic [6:0]  size_bits;
        logic        big_endian;
        logic        is_signed;
        logic [31:0] factor;
        logic [63:0] offset;
        logic        is_mux;
        logic [7:0]  mux_select;
        logic        new_message;
    } sig_req_t;

    // One decoded result.
    typedef struct {
        logic [63:0] value;
        status_t     status;
    } sig_result_t;

    // One row of the directed table; a fixed result is given where it is obvious.
    typedef struct {
        sig_req_t    req;
        bit          fixed;
        logic [63:0] value;
        status_t     status;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [63:0] frame_data, [67:64] frame_bytes, [73:68] start_bit, [80:74] size_bits,
    // [112:81] factor, [176:113] offset, [183:177] zero
    logic [183:0] s_axis_tdata;
    // [0] big_endian, [1] is_signed, [2] is_multiplexor, [10:3] mux_select,
    // [11] new_message, [15:12] zero
    logic [15:0]  s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [63:0] value
    logic [63:0]  m_axis_tdata;
    // [1:0] status, [7:2] zero
    logic [7:0]   m_axis_tuser;

    // Request currently on the input bus, with its fixed result if any.
    sig_req_t     bus_req;
    bit           bus_fixed;
    logic [63:0]  bus_fixed_value;
    status_t      bus_fixed_status;

    logic [7:0]   stored_mux = NO_FILTER;
    sig_result_t  pending_results[$];
    stim_row_t    directed_rows[$];
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  mismatches = 0;
    int unsigned  quiet_cycles = 0;

    can_signal_extractor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Decode one signal and update the stored multiplexor value.
    function automatic sig_result_t decode_signal(input sig_req_t r);
        sig_result_t res;
        int unsigned nbits;
        int unsigned st;
        int unsigned sz;
        int unsigned sb;
        logic [63:0] raw;
        logic [63:0] word;
        logic [63:0] sign_bit;
        logic [63:0] factor_ext;
        bit          fits;
        res.value  = '0;
        res.status = ST_OK;
        nbits = ((r.frame_bytes > 4'd8) ? 8 : r.frame_bytes) * 8;
        st = r.start_bit;
        sz = r.size_bits;
        if (r.new_message)
            stored_mux = NO_FILTER;
        fits = !(st >= nbits || sz < 1 || sz > nbits);
        // Motorola signals may only run down to the top of byte 0.
        if (fits)
            fits = r.big_endian ? (sz <= (st / 8) * 8 + 8 - st % 8) : (st + sz <= nbits);
        if (!r.is_mux && stored_mux != NO_FILTER && r.mux_select != stored_mux)
            res.status = ST_SKIP;
        else if (!fits)
            res.status = ST_RANGE;
        else
        begin
            if (r.big_endian)
            begin
                // Reverse bytes 0..sb so the start byte lands lowest.
                sb = st / 8;
                word = '0;
                for (int k = 0; k <= sb; k++)
                    word[8 * k +: 8] = r.frame_data[8 * (sb - k) +: 8];
                raw = word >> (st % 8);
            end
            else
                raw = r.frame_data >> st;
            if (sz < 64)
                raw &= (64'd1 << sz) - 64'd1;
            if (r.is_signed)
            begin
                sign_bit = 64'd1 << (sz - 1);
                raw = (raw ^ sign_bit) - sign_bit;
            end
            factor_ext = {{32{r.factor[31]}}, r.factor};
            res.value = raw * factor_ext + r.offset;
            if (r.is_mux)
            begin
                stored_mux = res.value[7:0];
                res.value  = {56'd0, res.value[7:0]};
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t ns: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic add_row(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic [5:0] st, input logic [6:0] sz, input logic be,
                           input logic sgn, input logic [31:0] fac, input logic [63:0] off,
                           input logic mux, input logic [7:0] sel, input logic newmsg,
                           input bit fixed, input logic [63:0] value, input status_t status);
        stim_row_t row;
        row.req = '{data, nbytes, st, sz, be, sgn, fac, off, mux, sel, newmsg};
        row.fixed  = fixed;
        row.value  = value;
        row.status = status;
        directed_rows.push_back(row);
    endtask

    // Drive one request from a falling edge and hold it until it is taken.
    task automatic send_request(input sig_req_t r, input bit fixed,
                                input logic [63:0] value, input status_t status);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        bus_req          <= r;
        bus_fixed        <= fixed;
        bus_fixed_value  <= value;
        bus_fixed_status <= status;
        s_axis_tdata     <= {7'd0, r.offset, r.factor, r.size_bits, r.start_bit,
                             r.frame_bytes, r.frame_data};
        s_axis_tuser     <= {4'd0, r.new_message, r.mux_select, r.is_mux,
                             r.is_signed, r.big_endian};
        s_axis_tvalid    <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random request: mostly signals that fit, with some noise and oversized frames.
    task automatic make_random_request(output sig_req_t r);
        int unsigned roll;
        int unsigned nbits;
        int unsigned cap;
        int unsigned avail;
        int unsigned st;
        int unsigned sz;
        roll = $urandom_range(99);
        r.frame_data  = {$urandom, $urandom};
        r.big_endian  = 1'($urandom_range(1));
        r.is_signed   = 1'($urandom_range(1));
        r.new_message = ($urandom_range(99) < 8);
        r.is_mux      = ($urandom_range(99) < 12);
        r.factor = ($urandom_range(1) == 1) ? 32'($urandom_range(8)) - 32'd4 : $urandom;
        r.offset = ($urandom_range(1) == 1) ? 64'($urandom_range(255)) : {$urandom, $urandom};
        if (stored_mux != NO_FILTER && $urandom_range(99) < 60)
            r.mux_select = stored_mux;
        else
            r.mux_select = 8'($urandom_range(255));
        if (roll < 10)
        begin
            r.frame_bytes = 4'($urandom_range(15));
            r.start_bit   = 6'($urandom_range(63));
            r.size_bits   = 7'($urandom_range(127));
        end
        else
        begin
            r.frame_bytes = 4'((roll < 15) ? $urandom_range(15, 9) : $urandom_range(8, 1));
            nbits = ((r.frame_bytes > 4'd8) ? 8 : r.frame_bytes) * 8;
            cap = 64;
            // Most selectors are plain bytes so that later signals match them.
            if (r.is_mux && $urandom_range(99) < 70)
            begin
                r.factor = 32'd1;
                r.offset = 64'd0;
                cap = 8;
            end
            if (r.big_endian)
            begin
                st = $urandom_range(nbits - 1, 0);
                avail = (st / 8) * 8 + 8 - st % 8;
            end
            else
                avail = nbits;
            if (avail > cap)
                avail = cap;
            if ($urandom_range(3) == 0)
                sz = $urandom_range(avail, 1);
            else
                sz = $urandom_range((avail < 16) ? avail : 16, 1);
            if (!r.big_endian)
                st = $urandom_range(nbits - sz, 0);
            r.start_bit = 6'(st);
            r.size_bits = 7'(sz);
        end
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // Check results against the oldest expectation, then record new requests.
    always @(posedge clk)
    begin
        sig_result_t want;
        sig_result_t pred;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch("value", m_axis_tdata, want.value);
                if (m_axis_tuser !== {6'd0, want.status})
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pred = decode_signal(bus_req);
            if (bus_fixed)
            begin
                pred.value  = bus_fixed_value;
                pred.status = bus_fixed_status;
            end
            pending_results.push_back(pred);
        end
    end

    // Watchdog on cycles in which no request or result moves.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        sig_req_t req;
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = '0;
        bus_fixed        = 1'b0;
        bus_fixed_value  = '0;
        bus_fixed_status = ST_OK;
        bus_req          = '{default: '0};
        send_idle_pct    = 32;
        recv_stall_pct   = 73;

        // Plain extraction and the extremes of size and frame length.
        add_row(64'hA5, 8, 0, 8, 0, 0, 32'd1, 64'd0, 0, 8'hFF, 0, 1, 64'hA5, ST_OK);
        add_row('1, 8, 0, 64, 0, 0, 32'd1, 64'd0, 0, 8'h00, 0, 1, '1, ST_OK);
        add_row('1, 8, 0, 64, 0, 1, '1, 64'd0, 0, 8'h00, 0, 1, 64'd1, ST_OK);
        add_row(64'h0123456789ABCDEF, 8, 0, 0, 0, 0, 32'd1, 64'd5, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        add_row(64'h0123456789ABCDEF, 8, 0, 127, 0, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        add_row(64'h0123456789ABCDEF, 8, 0, 65, 1, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        add_row(64'h0123456789ABCDEF, 0, 0, 1, 0, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        add_row(64'h0123456789ABCDEF, 15, 0, 64, 0, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'h0123456789ABCDEF, ST_OK);
        // Start outside the frame and an Intel signal past its end.
        add_row(64'h0123456789ABCDEF, 2, 16, 1, 0, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        add_row(64'h0123456789ABCDEF, 2, 10, 7, 0, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        // Motorola signals at the edge of byte 0 and at the top of the frame.
        add_row(64'hFEDCBA9876543210, 8, 3, 6, 1, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        add_row(64'hFEDCBA9876543210, 8, 3, 5, 1, 1, 32'd3, 64'd7, 0, 8'h00, 0,
                0, 64'd0, ST_OK);
        add_row(64'hFEDCBA9876543210, 8, 63, 57, 1, 1, 32'd1, 64'd0, 0, 8'h00, 0,
                0, 64'd0, ST_OK);
        add_row(64'hFEDCBA9876543210, 8, 63, 58, 1, 0, 32'd1, 64'd0, 0, 8'h00, 0,
                1, 64'd0, ST_RANGE);
        // Extremes of factor and offset.
        add_row(64'h00000000000ABC00, 8, 12, 12, 1, 1, 32'h7FFFFFFF, 64'h8000000000000000,
                0, 8'h00, 0, 0, 64'd0, ST_OK);
        add_row(64'h8000000000000000, 8, 63, 1, 0, 0, 32'h80000000, 64'h7FFFFFFFFFFFFFFF,
                0, 8'h00, 0, 0, 64'd0, ST_OK);
        // Multiplexor store, match, skip, and skip ahead of the range check.
        add_row(64'h03, 8, 0, 8, 0, 0, 32'd1, 64'd0, 1, 8'hAA, 0, 1, 64'd3, ST_OK);
        add_row(64'h5A5A5A5A5A5A5A5A, 8, 8, 16, 0, 1, 32'd2, 64'd1, 0, 8'h03, 0,
                0, 64'd0, ST_OK);
        add_row(64'h5A5A5A5A5A5A5A5A, 8, 0, 0, 0, 0, 32'd1, 64'd0, 0, 8'h04, 0,
                1, 64'd0, ST_SKIP);
        // A multiplexor out of range keeps the stored selector.
        add_row(64'h1234, 1, 8, 8, 0, 0, 32'd1, 64'd0, 1, 8'h00, 0, 1, 64'd0, ST_RANGE);
        add_row(64'h1234, 8, 0, 8, 0, 0, 32'd1, 64'd0, 0, 8'h04, 0, 1, 64'd0, ST_SKIP);
        // A new message clears the filter.
        add_row(64'h1234, 8, 0, 8, 0, 0, 32'd1, 64'd0, 0, 8'h09, 1, 0, 64'd0, ST_OK);
        // Selector taken from the low byte after scaling, then the no-filter value.
        add_row(64'h81, 8, 0, 8, 0, 0, 32'd2, 64'h100, 1, 8'h00, 0, 1, 64'd2, ST_OK);
        add_row(64'hFF, 8, 0, 8, 0, 0, 32'd1, 64'd0, 1, 8'h00, 0, 1, 64'd255, ST_OK);
        add_row(64'hC3C3, 8, 4, 9, 0, 1, 32'd1, 64'd0, 0, 8'h12, 0, 0, 64'd0, ST_OK);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed,
                         directed_rows[i].value, directed_rows[i].status);

        // Random phases; the sender holds off between them until all results are back.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            s_axis_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge clk);
            send_idle_pct  = (phase == 0) ? 32 : (phase == 1) ? 73 : 0;
            recv_stall_pct = (phase == 0) ? 73 : (phase == 1) ? 32 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                make_random_request(req);
                send_request(req, 1'b0, 64'd0, ST_OK);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
